@@ rtl/wrm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wrm_pkg;
  localparam int NUM_WORKERS = 64;
  localparam int NUM_TYPES   = 8;
  localparam int UNIT_WIDTH  = 16;
  localparam int WW          = 6;
  localparam int TW          = 3;
  localparam int CW          = 7;
  localparam logic [UNIT_WIDTH-1:0] UNIT_MAX = {UNIT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_MATCH_TYPE = 2'd1,
    OP_MATCH_TGT  = 2'd2,
    OP_REMOVE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_MATCH = 2'd1,
    STAT_CONFLICT = 2'd2,
    STAT_BAD      = 2'd3
  } status_t;

  typedef struct packed {
    op_t                   op;
    logic [WW-1:0]         worker;
    logic [TW-1:0]         wtype;
    logic [UNIT_WIDTH-1:0] units;
    logic                  blocking;
    logic                  units_zero;
  } cmd_t;

  typedef struct packed {
    status_t               status;
    logic                  matched;
    logic [WW-1:0]         matched_worker;
    logic [UNIT_WIDTH-1:0] remaining_units;
    logic [CW-1:0]         queue_size;
    logic [CW-1:0]         blocked_total;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/worker_request_matcher.sv @@
// worker request matcher: one pending work request per worker, kept in
// arrival order per work type.
// input channel in_valid/in_ready carries one command per transaction:
// add, match by type, match by target worker, or remove units.
// output channel out_valid/out_ready returns exactly one result per command:
// status, matched worker, remaining units, queue size and blocked count.
// a two-entry command queue sits in front of the executor, so commands are
// taken while the executor or the receiver is busy.
// the executor reads the worker entry and its list links from the entry
// memories when it takes a command, then updates entry, links and
// head/tail registers; it takes a new command only once the last one is done.
// when the receiver stalls, the result stays in the output register and the
// executor holds its next command; the queue fills and then in_ready drops.
// reset (synchronous, active low) empties all requests and the queue;
// entry contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module worker_request_matcher import wrm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_op,
  input  wire logic [WW-1:0]         in_worker,
  input  wire logic [TW-1:0]         in_work_type,
  input  wire logic [UNIT_WIDTH-1:0] in_unit_count,
  input  wire logic                  in_blocking,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_status,
  output logic                       out_matched,
  output logic [WW-1:0]              out_matched_worker,
  output logic [UNIT_WIDTH-1:0]      out_remaining_units,
  output logic [CW-1:0]              out_queue_size,
  output logic [CW-1:0]              out_blocked_total
);
  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  wrm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_worker    (in_worker),
    .in_work_type (in_work_type),
    .in_unit_count(in_unit_count),
    .in_blocking  (in_blocking),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd)
  );

  wrm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res)
  );

  assign out_status          = res.status;
  assign out_matched         = res.matched;
  assign out_matched_worker  = res.matched_worker;
  assign out_remaining_units = res.remaining_units;
  assign out_queue_size      = res.queue_size;
  assign out_blocked_total   = res.blocked_total;
endmodule
`default_nettype wire

@@ rtl/wrm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wrm_front import wrm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_op,
  input  wire logic [WW-1:0]         in_worker,
  input  wire logic [TW-1:0]         in_work_type,
  input  wire logic [UNIT_WIDTH-1:0] in_unit_count,
  input  wire logic                  in_blocking,
  output logic                       cmd_valid,
  input  wire logic                  cmd_pop,
  output cmd_t                       cmd
);
  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       c_in;
  logic       push;

  // classify the incoming transaction
  always_comb begin
    c_in.op         = op_t'(in_op);
    c_in.worker     = in_worker;
    c_in.wtype      = in_work_type;
    c_in.units      = in_unit_count;
    c_in.blocking   = in_blocking;
    c_in.units_zero = (in_unit_count == '0);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ cmd_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= c_in;
    end
  end
endmodule
`default_nettype wire

@@ rtl/wrm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wrm_back import wrm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  output logic      cmd_pop,
  input  wire cmd_t cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res
);
  localparam int EW = TW + UNIT_WIDTH + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r;
  logic [WW-1:0] addr_r;

  logic [EW-1:0] ent_mem [NUM_WORKERS];
  logic [WW-1:0] next_mem [NUM_WORKERS];
  logic [WW-1:0] prev_mem [NUM_WORKERS];
  logic [EW-1:0] ent_rd;
  logic [WW-1:0] nx_rd, pv_rd;

  logic [NUM_WORKERS-1:0] valid_r, valid_nxt;
  logic [WW-1:0] head_r [NUM_TYPES];
  logic [WW-1:0] head_nxt [NUM_TYPES];
  logic [WW-1:0] tail_r [NUM_TYPES];
  logic [WW-1:0] tail_nxt [NUM_TYPES];
  logic [NUM_TYPES-1:0] ne_r, ne_nxt;
  logic [CW-1:0] pend_r, pend_nxt, blkc_r, blkc_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          res_r, res_nxt;

  logic          ent_we;
  logic [EW-1:0] ent_wd;
  logic          next_we, prev_we;
  logic [WW-1:0] next_wa, next_wd, prev_wa, prev_wd;

  logic [TW-1:0]         e_type;
  logic [UNIT_WIDTH-1:0] e_units;
  logic                  e_blk, v, adv;
  logic                  do_take, do_unlink, do_append, is_head, is_tail;
  logic [UNIT_WIDTH-1:0] take_n, left_units;
  logic [UNIT_WIDTH:0]   sum;
  logic [TW-1:0]         ut;
  logic [WW-1:0]         rd_addr;

  assign {e_type, e_units, e_blk} = ent_rd;
  assign v         = valid_r[addr_r];
  assign adv       = !out_valid_r || out_ready;
  assign cmd_pop   = cmd_valid && (state_r == S_IDLE);
  assign rd_addr   = (cmd.op == OP_MATCH_TYPE) ? head_r[cmd.wtype] : cmd.worker;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    ne_nxt        = ne_r;
    pend_nxt      = pend_r;
    blkc_nxt      = blkc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    ent_we        = 1'b0;
    ent_wd        = ent_rd;
    next_we       = 1'b0;
    next_wa       = pv_rd;
    next_wd       = nx_rd;
    prev_we       = 1'b0;
    prev_wa       = nx_rd;
    prev_wd       = pv_rd;
    do_take       = 1'b0;
    do_unlink     = 1'b0;
    do_append     = 1'b0;
    take_n        = cmd_r.units;
    left_units    = e_units - take_n;
    sum           = {1'b0, e_units} + {1'b0, cmd_r.units};
    ut            = e_type;
    is_head       = 1'b0;
    is_tail       = 1'b0;
    res_nxt.status          = STAT_OK;
    res_nxt.matched         = 1'b0;
    res_nxt.matched_worker  = '0;
    res_nxt.remaining_units = '0;

    unique case (state_r)
      S_IDLE: begin
        res_nxt = res_r;
        if (cmd_pop) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!adv) begin
          res_nxt = res_r;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          unique case (cmd_r.op)
            OP_ADD: begin
              if (cmd_r.units_zero) begin
                res_nxt.status = STAT_BAD;
              end else if (v) begin
                if (e_type != cmd_r.wtype) begin
                  res_nxt.status          = STAT_CONFLICT;
                  res_nxt.remaining_units = e_units;
                end else begin
                  ent_we = 1'b1;
                  ent_wd = {e_type, (sum[UNIT_WIDTH] ? UNIT_MAX : sum[UNIT_WIDTH-1:0]),
                            e_blk | cmd_r.blocking};
                  if (cmd_r.blocking && !e_blk) begin
                    blkc_nxt = blkc_r + 1'b1;
                  end
                  res_nxt.remaining_units = sum[UNIT_WIDTH] ? UNIT_MAX : sum[UNIT_WIDTH-1:0];
                end
              end else begin
                ent_we             = 1'b1;
                ent_wd             = {cmd_r.wtype, cmd_r.units, cmd_r.blocking};
                valid_nxt[addr_r]  = 1'b1;
                do_append          = 1'b1;
                pend_nxt           = pend_r + 1'b1;
                blkc_nxt           = blkc_r + {{(CW-1){1'b0}}, cmd_r.blocking};
                res_nxt.remaining_units = cmd_r.units;
              end
            end
            OP_MATCH_TYPE: begin
              if (ne_r[cmd_r.wtype]) begin
                do_take = 1'b1;
                take_n  = {{(UNIT_WIDTH-1){1'b0}}, 1'b1};
                res_nxt.matched        = 1'b1;
                res_nxt.matched_worker = addr_r;
              end else begin
                res_nxt.status = STAT_NO_MATCH;
              end
            end
            OP_MATCH_TGT: begin
              if (v && e_type == cmd_r.wtype) begin
                do_take = 1'b1;
                take_n  = {{(UNIT_WIDTH-1){1'b0}}, 1'b1};
                res_nxt.matched        = 1'b1;
                res_nxt.matched_worker = addr_r;
              end else begin
                res_nxt.status = STAT_NO_MATCH;
              end
            end
            OP_REMOVE: begin
              if (cmd_r.units_zero || !v) begin
                res_nxt.status = STAT_BAD;
              end else if (cmd_r.units > e_units) begin
                res_nxt.status          = STAT_BAD;
                res_nxt.remaining_units = e_units;
              end else begin
                do_take = 1'b1;
              end
            end
            default: ;
          endcase

          left_units = e_units - take_n;
          if (do_take) begin
            if (e_blk && blkc_r != '0) begin
              blkc_nxt = blkc_r - 1'b1;
            end
            ent_we = 1'b1;
            ent_wd = {e_type, left_units, 1'b0};
            res_nxt.remaining_units = left_units;
            if (left_units == '0) begin
              do_unlink         = 1'b1;
              valid_nxt[addr_r] = 1'b0;
              if (pend_r != '0) begin
                pend_nxt = pend_r - 1'b1;
              end
            end
          end

          // unlink from the type order
          if (do_unlink) begin
            is_head = (head_r[ut] == addr_r);
            is_tail = (tail_r[ut] == addr_r);
            priority if (is_head && is_tail) begin
              ne_nxt[ut] = 1'b0;
            end else if (is_head) begin
              head_nxt[ut] = nx_rd;
            end else if (is_tail) begin
              tail_nxt[ut] = pv_rd;
            end else begin
              next_we = 1'b1;
              prev_we = 1'b1;
            end
          end

          // append to the tail of the type order
          if (do_append) begin
            if (ne_r[cmd_r.wtype]) begin
              next_we = 1'b1;
              next_wa = tail_r[cmd_r.wtype];
              next_wd = addr_r;
              prev_we = 1'b1;
              prev_wa = addr_r;
              prev_wd = tail_r[cmd_r.wtype];
            end else begin
              head_nxt[cmd_r.wtype] = addr_r;
              ne_nxt[cmd_r.wtype]   = 1'b1;
            end
            tail_nxt[cmd_r.wtype] = addr_r;
          end
          res_nxt.queue_size    = pend_nxt;
          res_nxt.blocked_total = blkc_nxt;
        end
      end
      default: begin
        res_nxt   = res_r;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      ne_r        <= '0;
      pend_r      <= '0;
      blkc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      ne_r        <= ne_nxt;
      pend_r      <= pend_nxt;
      blkc_r      <= blkc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    res_r  <= res_nxt;
    if (cmd_pop) begin
      cmd_r  <= cmd;
      addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      ent_rd <= ent_mem[rd_addr];
      nx_rd  <= next_mem[rd_addr];
      pv_rd  <= prev_mem[rd_addr];
    end
    if (ent_we) begin
      ent_mem[addr_r] <= ent_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
  end
endmodule
`default_nettype wire

@@ test/worker_request_matcher_tb.sv @@
`timescale 1ns / 1ps
module worker_request_matcher_tb;
  import wrm_pkg::*;

  class request_book;
    logic                  live [NUM_WORKERS];
    logic [TW-1:0]         kind [NUM_WORKERS];
    logic [UNIT_WIDTH-1:0] units [NUM_WORKERS];
    logic                  blk [NUM_WORKERS];
    int                    fifo [NUM_TYPES][$];
    int                    pending;
    int                    blocked;
    res_t                  expected [$];
    int                    errors;

    function void clear();
      for (int i = 0; i < NUM_WORKERS; i++) begin
        live[i] = 0; units[i] = 0; blk[i] = 0; kind[i] = 0;
      end
      for (int t = 0; t < NUM_TYPES; t++) fifo[t].delete();
      pending = 0; blocked = 0; errors = 0;
      expected.delete();
    endfunction

    function void take(int w, int n);
      if (blk[w]) begin
        blk[w] = 0;
        blocked--;
      end
      if (units[w] == n) begin
        foreach (fifo[kind[w]][i])
          if (fifo[kind[w]][i] == w) begin
            fifo[kind[w]].delete(i);
            break;
          end
        live[w] = 0; units[w] = 0; pending--;
      end else begin
        units[w] = units[w] - n;
      end
    endfunction

    function void note_command(op_t op, int w, int t, int cnt, logic b);
      res_t r;
      int sum;
      r = '0;
      r.status = STAT_OK;
      case (op)
        OP_ADD: begin
          if (cnt == 0) r.status = STAT_BAD;
          else if (live[w]) begin
            if (kind[w] != t) r.status = STAT_CONFLICT;
            else begin
              sum = units[w] + cnt;
              units[w] = (sum > UNIT_MAX) ? UNIT_MAX : sum;
              if (b && !blk[w]) begin
                blk[w] = 1; blocked++;
              end
            end
            r.remaining_units = units[w];
          end else begin
            live[w] = 1; kind[w] = t; units[w] = cnt; blk[w] = b;
            fifo[t].push_back(w);
            pending++;
            if (b) blocked++;
            r.remaining_units = cnt;
          end
        end
        OP_MATCH_TYPE: begin
          if (fifo[t].size() > 0) begin
            int h;
            h = fifo[t][0];
            take(h, 1);
            r.matched = 1; r.matched_worker = h; r.remaining_units = units[h];
          end else r.status = STAT_NO_MATCH;
        end
        OP_MATCH_TGT: begin
          if (live[w] && kind[w] == t) begin
            take(w, 1);
            r.matched = 1; r.matched_worker = w; r.remaining_units = units[w];
          end else r.status = STAT_NO_MATCH;
        end
        default: begin
          if (cnt == 0 || !live[w]) r.status = STAT_BAD;
          else if (cnt > units[w]) begin
            r.status = STAT_BAD; r.remaining_units = units[w];
          end else begin
            take(w, cnt);
            r.remaining_units = units[w];
          end
        end
      endcase
      r.queue_size = pending;
      r.blocked_total = blocked;
      expected.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = expected.pop_front();
      if (got.status != e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.matched != e.matched) begin
        $error("matched exp %0d got %0d", e.matched, got.matched); errors++;
      end
      if (got.matched_worker != e.matched_worker) begin
        $error("matched_worker exp %0d got %0d", e.matched_worker, got.matched_worker);
        errors++;
      end
      if (got.remaining_units != e.remaining_units) begin
        $error("remaining_units exp %0d got %0d", e.remaining_units, got.remaining_units);
        errors++;
      end
      if (got.queue_size != e.queue_size) begin
        $error("queue_size exp %0d got %0d", e.queue_size, got.queue_size); errors++;
      end
      if (got.blocked_total != e.blocked_total) begin
        $error("blocked_total exp %0d got %0d", e.blocked_total, got.blocked_total);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_valid = 0;
  logic                  in_ready;
  logic [1:0]            in_op = '0;
  logic [WW-1:0]         in_worker = '0;
  logic [TW-1:0]         in_work_type = '0;
  logic [UNIT_WIDTH-1:0] in_unit_count = '0;
  logic                  in_blocking = 0;
  logic                  out_valid;
  logic                  out_ready = 0;
  logic [1:0]            out_status;
  logic                  out_matched;
  logic [WW-1:0]         out_matched_worker;
  logic [UNIT_WIDTH-1:0] out_remaining_units;
  logic [CW-1:0]         out_queue_size;
  logic [CW-1:0]         out_blocked_total;

  request_book book;
  bit          stimulus_done = 0;
  bit          hold_sink = 0;

  always #5 clk = ~clk;

  worker_request_matcher i_dut (.*);

  task automatic send(op_t op, int w, int t, int cnt, logic b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; in_op <= op; in_worker <= w; in_work_type <= t;
    in_unit_count <= cnt; in_blocking <= b;
    do @(posedge clk); while (!in_ready);
    book.note_command(op, w, t, cnt, b);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(negedge clk); while (book.expected.size() > 0);
  endtask

  task automatic random_command(int nw);
    int w;
    int t;
    int r;
    int cnt;
    w = $urandom_range(0, nw - 1);
    t = $urandom_range(0, 7);
    r = $urandom_range(0, 99);
    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4);
    if (r < 35) send(OP_ADD, w, t, cnt, $urandom_range(0, 1));
    else if (r < 60) send(OP_MATCH_TYPE, w, t, cnt, $urandom_range(0, 1));
    else if (r < 80) begin
      if (book.live[w] && $urandom_range(0, 3) != 0) t = book.kind[w];
      send(OP_MATCH_TGT, w, t, cnt, $urandom_range(0, 1));
    end else begin
      if (book.live[w] && $urandom_range(0, 2) != 0) cnt = $urandom_range(1, book.units[w]);
      send(OP_REMOVE, w, t, cnt, $urandom_range(0, 1));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_result({status_t'(out_status), out_matched, out_matched_worker,
                         out_remaining_units, out_queue_size, out_blocked_total});
  end

  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        out_ready <= 0;
        repeat (60) @(negedge clk);
        hold_sink = 0;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      do @(negedge clk); while (!(out_valid && out_ready) && !hold_sink);
    end
  end

  initial begin
    #3000000;
    $display("[worker_request_matcher] ERROR");
    $finish;
  end

  initial begin
    book = new();
    book.clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    send(OP_REMOVE, 0, 0, 1, 0);
    send(OP_MATCH_TYPE, 0, 7, 1, 0);
    send(OP_ADD, 0, 0, 0, 1);
    send(OP_ADD, 63, 7, 65535, 1);
    send(OP_ADD, 63, 7, 10, 1);
    send(OP_ADD, 63, 3, 1, 0);
    send(OP_ADD, 5, 7, 2, 0);
    send(OP_ADD, 9, 7, 3, 1);
    send(OP_MATCH_TYPE, 0, 7, 1, 0);
    send(OP_MATCH_TYPE, 0, 7, 1, 0);
    send(OP_MATCH_TGT, 9, 7, 1, 0);
    send(OP_MATCH_TGT, 9, 2, 1, 0);
    send(OP_REMOVE, 63, 0, 65535, 0);
    send(OP_REMOVE, 63, 0, 0, 0);
    send(OP_REMOVE, 63, 0, 65533, 0);
    send(OP_REMOVE, 9, 0, 2, 0);
    send(OP_REMOVE, 5, 0, 1, 0);
    send(OP_MATCH_TGT, 0, 0, 0, 1);
    drain();
    hold_sink = 1;
    for (int i = 0; i < 20; i++) begin
      in_valid <= 1; in_op <= OP_ADD; in_worker <= i; in_work_type <= i % 8;
      in_unit_count <= 1 + i; in_blocking <= i[0];
      do @(posedge clk); while (!in_ready);
      book.note_command(OP_ADD, i, i % 8, 1 + i, i[0]);
      @(negedge clk);
    end
    for (int i = 0; i < 630; i++) begin
      random_command((i < 300) ? 12 : 64);
      if (i == 315) drain();
    end
    drain();
    repeat (20) @(negedge clk);
    if (book.errors == 0 && book.expected.size() == 0)
      $display("[worker_request_matcher] OK");
    else
      $display("[worker_request_matcher] ERROR");
    $finish;
  end
endmodule
